@@ rtl/opp_pkg.sv @@
// ============================================================================
// opp_pkg: shared types and constants of the onset peak picker
// Sizes, register indexes, reset values, and the command and status
// structs that join the controller to the datapath.
// ============================================================================
package opp_pkg;

    // Capacity of the frame store and the analysis window.
    localparam int MAX_FRAMES = 4096;
    localparam int CHANNELS   = 4;
    localparam int MAX_WINDOW = 16;

    // Derived sizes.
    localparam int FRAME_AW = $clog2(MAX_FRAMES);
    localparam int FCNT_W   = FRAME_AW + 1;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WIN_AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SCAN_W   = WIN_AW + 1;

    // Field widths of the ports.
    localparam int DET_W      = 16;
    localparam int CFG_W      = 16;
    localparam int WLEN_W     = 5;
    localparam int CFG_AW     = 3;
    localparam int FRAMENO_W  = 12;
    localparam int TIME_W     = 28;

    // Arithmetic widths.
    localparam int NRM_W    = DET_W + 1;          // scaled value, Q1.16
    localparam int PROD_W   = NRM_W + CFG_W;      // scaled value times weight
    localparam int D_W      = 34;                 // detection and smoothed value
    localparam int HSUM_W   = D_W + WIN_AW;       // sum over the window
    localparam int DIV_N_W  = HSUM_W;             // divider dividend
    localparam int DIV_D_W  = NRM_W;              // divider divisor
    localparam int WSUM_W   = CFG_W + CH_W;       // sum of the weights
    localparam int FLOOR_W  = CFG_W + WSUM_W;     // silence floor
    localparam int HALF_W   = D_W / 2;            // width of each half of the mean for alpha
    localparam int PHALF_W  = HALF_W + CFG_W;
    localparam int AMUL_W   = D_W + CFG_W;
    localparam int ALPHA_SH = 12;
    localparam int THR_W    = AMUL_W - ALPHA_SH + 1;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_WEIGHT_0 = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_WEIGHT_1 = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_WEIGHT_2 = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_WEIGHT_3 = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_ALPHA    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_SILENCE  = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_WINDOW   = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_PERIOD   = 3'd7;

    // Configuration reset values.
    localparam logic [CFG_W-1:0]  RST_WEIGHT_ON  = 16'd4096;
    localparam logic [CFG_W-1:0]  RST_WEIGHT_OFF = 16'd0;
    localparam logic [CFG_W-1:0]  RST_ALPHA      = 16'd410;
    localparam logic [CFG_W-1:0]  RST_SILENCE    = 16'd1311;
    localparam logic [WLEN_W-1:0] RST_WINDOW     = 5'd5;
    localparam logic [CFG_W-1:0]  RST_PERIOD     = 16'd11610;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic a_init;
        logic rd_frame;
        logic latch_row;
        logic div_chan;
        logic mac;
        logic acc;
        logic hist;
        logic div_mean;
        logic silence;
        logic win_wr;
        logic scan;
        logic div_wmean;
        logic am_lo;
        logic am_hi;
        logic thr;
        logic keep;
        logic finish;
        logic f_rd;
        logic f_mul;
        logic f_out;
    } opp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic frame_more;
        logic chan_last;
        logic peak_zero;
        logic first_frame;
        logic scan_done;
        logic slot_free;
    } opp_sts_t;

endpackage

@@ rtl/onset_peak_picker.sv @@
// ============================================================================
// onset_peak_picker: offline onset picking over four detection channels
// A load is taken in the idle state; a fetch reads the onset list, forms the
// onset time and then waits for a free output register.
// The load that ends a sequence runs the analysis over every stored frame,
// paced by the shared bit-serial divider (up to six 38-step divisions per
// frame). Reset clears the frame count, peaks and onset list.
// ============================================================================
module onset_peak_picker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [opp_pkg::DET_W-1:0]       det_0,
    input  logic [opp_pkg::DET_W-1:0]       det_1,
    input  logic [opp_pkg::DET_W-1:0]       det_2,
    input  logic [opp_pkg::DET_W-1:0]       det_3,
    input  logic                            last_frame,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [opp_pkg::FRAMENO_W-1:0]   onset_frame,
    output logic [opp_pkg::TIME_W-1:0]      onset_time,
    output logic                            found,
    output logic                            final_onset,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [opp_pkg::CFG_AW-1:0]      cfg_index,
    input  logic [opp_pkg::CFG_W-1:0]       cfg_data
);
    import opp_pkg::*;

    opp_cmd_t cmd;
    opp_sts_t sts;
    logic [CHANNELS-1:0][DET_W-1:0] det;

    // Channel values gathered into one vector.
    assign det       = {det_3, det_2, det_1, det_0};
    assign cfg_ready = 1'b1;

    opp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .mode       (mode),
        .last_frame (last_frame),
        .sts        (sts),
        .cmd        (cmd),
        .in_ready   (in_ready)
    );

    opp_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .det         (det),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .onset_frame (onset_frame),
        .onset_time  (onset_time),
        .found       (found),
        .final_onset (final_onset)
    );

`ifndef NO_ASSERTIONS
    // A result with nothing found carries all-zero fields.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (onset_frame == '0 && onset_time == '0 && !final_onset))
        else $error("empty result carries nonzero fields");

    // A fetch keeps the input side closed on the next cycle.
    a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode) |=> !in_ready)
        else $error("input accepted during a fetch");

    // The final load of a sequence starts the analysis.
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !mode && last_frame) |=> !in_ready)
        else $error("input accepted during the analysis");
`endif

endmodule

@@ rtl/opp_div.sv @@
// ============================================================================
// opp_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, shared by the channel
// scaling and the two window means.
// ============================================================================
module opp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [opp_pkg::DIV_N_W-1:0] dividend,
    input  logic [opp_pkg::DIV_D_W-1:0] divisor,
    output logic                        done,
    output logic [opp_pkg::DIV_N_W-1:0] quotient
);
    import opp_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] dvs_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W:0]   rem_sh;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    // One restoring step.
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DIV_N_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        ge     = rem_sh >= {1'b0, dvs_reg};
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/opp_ctrl.sv @@
// ============================================================================
// opp_ctrl: sequencing state machine of the onset peak picker
// Accepts loads and fetches, and steps the datapath through the per-frame
// analysis and the fetch of one onset.
// ============================================================================
module opp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              mode,
    input  logic              last_frame,
    input  opp_pkg::opp_sts_t sts,
    output opp_pkg::opp_cmd_t cmd,
    output logic              in_ready
);
    import opp_pkg::*;

    typedef enum logic [23:0] {
        S_IDLE   = 24'h000001,
        S_INIT   = 24'h000002,
        S_RD     = 24'h000004,
        S_RDW    = 24'h000008,
        S_DIVS   = 24'h000010,
        S_DIV    = 24'h000020,
        S_MAC    = 24'h000040,
        S_ACC    = 24'h000080,
        S_HIST   = 24'h000100,
        S_MDIVS  = 24'h000200,
        S_MDIV   = 24'h000400,
        S_SIL    = 24'h000800,
        S_WIN    = 24'h001000,
        S_SCAN   = 24'h002000,
        S_WDIVS  = 24'h004000,
        S_WDIV   = 24'h008000,
        S_AM1    = 24'h010000,
        S_AM2    = 24'h020000,
        S_THR    = 24'h040000,
        S_KEEP   = 24'h080000,
        S_FIN    = 24'h100000,
        S_FRD    = 24'h200000,
        S_FMUL   = 24'h400000,
        S_FOUT   = 24'h800000
    } opp_state_t;

    opp_state_t state_reg;
    opp_state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (mode)
                    begin
                        state_next = S_FRD;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        if (last_frame)
                            state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.a_init = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                if (sts.frame_more)
                begin
                    cmd.rd_frame = 1'b1;
                    state_next   = S_RDW;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_RDW:
            begin
                cmd.latch_row = 1'b1;
                state_next    = S_DIVS;
            end
            S_DIVS:
            begin
                if (sts.peak_zero)
                begin
                    state_next = S_MAC;
                end
                else
                begin
                    cmd.div_chan = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                cmd.mac    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.chan_last ? S_HIST : S_DIVS;
            end
            S_HIST:
            begin
                cmd.hist   = 1'b1;
                state_next = S_MDIVS;
            end
            S_MDIVS:
            begin
                cmd.div_mean = 1'b1;
                state_next   = S_MDIV;
            end
            S_MDIV:
            begin
                if (sts.div_done)
                    state_next = S_SIL;
            end
            S_SIL:
            begin
                cmd.silence = 1'b1;
                state_next  = sts.first_frame ? S_KEEP : S_WIN;
            end
            S_WIN:
            begin
                cmd.win_wr = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                    state_next = S_WDIVS;
            end
            S_WDIVS:
            begin
                cmd.div_wmean = 1'b1;
                state_next    = S_WDIV;
            end
            S_WDIV:
            begin
                if (sts.div_done)
                    state_next = S_AM1;
            end
            S_AM1:
            begin
                cmd.am_lo  = 1'b1;
                state_next = S_AM2;
            end
            S_AM2:
            begin
                cmd.am_hi  = 1'b1;
                state_next = S_THR;
            end
            S_THR:
            begin
                cmd.thr    = 1'b1;
                state_next = S_KEEP;
            end
            S_KEEP:
            begin
                cmd.keep   = 1'b1;
                state_next = S_RD;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_FRD:
            begin
                cmd.f_rd   = 1'b1;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                cmd.f_mul  = 1'b1;
                state_next = S_FOUT;
            end
            S_FOUT:
            begin
                if (sts.slot_free)
                begin
                    cmd.f_out  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/opp_dpath.sv @@
// ============================================================================
// opp_dpath: datapath of the onset peak picker
// Frame store, channel peaks, configuration registers, smoothing and
// threshold windows, onset list memory and the output register.
// ============================================================================
module opp_dpath (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  opp_pkg::opp_cmd_t                          cmd,
    output opp_pkg::opp_sts_t                          sts,
    input  logic [opp_pkg::CHANNELS-1:0][opp_pkg::DET_W-1:0] det,
    input  logic                                       cfg_we,
    input  logic [opp_pkg::CFG_AW-1:0]                 cfg_index,
    input  logic [opp_pkg::CFG_W-1:0]                  cfg_data,
    input  logic                                       out_ready,
    output logic                                       out_valid,
    output logic [opp_pkg::FRAMENO_W-1:0]              onset_frame,
    output logic [opp_pkg::TIME_W-1:0]                 onset_time,
    output logic                                       found,
    output logic                                       final_onset
);
    import opp_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0]  weight_reg [CHANNELS];
    logic [CFG_W-1:0]  alpha_reg;
    logic [CFG_W-1:0]  silence_reg;
    logic [WLEN_W-1:0] window_reg;
    logic [CFG_W-1:0]  period_reg;

    // Load state.
    logic [FCNT_W-1:0] total_reg;
    logic [DET_W-1:0]  peak_reg [CHANNELS];
    logic              ready_reg;
    logic [FCNT_W-1:0] rp_reg;
    logic [FCNT_W-1:0] cnt_reg;

    // Memories.
    logic [CHANNELS*DET_W-1:0] fmem [MAX_FRAMES];
    logic [CHANNELS*DET_W-1:0] fmem_q;
    logic [FRAME_AW-1:0]       lmem [MAX_FRAMES];
    logic [FRAME_AW-1:0]       lmem_q;

    // Analysis state.
    logic [FCNT_W-1:0]  i_reg;
    logic [CH_W-1:0]    c_reg;
    logic [CHANNELS*DET_W-1:0] row_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [D_W-1:0]     d_reg;
    logic [D_W-1:0]     hist_reg [MAX_WINDOW];
    logic [D_W-1:0]     win_reg [MAX_WINDOW];
    logic [WIN_AW-1:0]  hpos_reg;
    logic [WIN_AW-1:0]  wpos_reg;
    logic [HSUM_W-1:0]  hsum_reg;
    logic [HSUM_W-1:0]  wtot_reg;
    logic [FLOOR_W-1:0] floor_reg;
    logic [D_W-1:0]     m_reg;
    logic [SCAN_W-1:0]  scan_reg;
    logic               cand_vld_reg;
    logic [D_W-1:0]     cand_reg;
    logic [D_W-1:0]     lo_reg;
    logic [D_W-1:0]     hi_reg;
    logic [PHALF_W-1:0] plo_reg;
    logic [PHALF_W-1:0] phi_reg;
    logic [THR_W-1:0]   thr_reg;
    logic               f1_reg;
    logic               f2_reg;

    // Fetch and output.
    logic [FRAME_AW-1:0]  ofr_reg;
    logic [TIME_W-1:0]    otime_reg;
    logic                 out_valid_reg;
    logic [FRAMENO_W-1:0] onset_frame_reg;
    logic [TIME_W-1:0]    onset_time_reg;
    logic                 found_reg;
    logic                 final_reg;

    // Combinational helpers.
    logic [FCNT_W-1:0]  eff_total;
    logic               store_ok;
    logic [SCAN_W-1:0]  len_eff;
    logic [WIN_AW-1:0]  hpos_inc;
    logic [WIN_AW-1:0]  wpos_inc;
    logic [DET_W-1:0]   cur_det;
    logic [DET_W-1:0]   cur_peak;
    logic [CFG_W-1:0]   cur_weight;
    logic [WSUM_W-1:0]  wsum;
    logic [DIV_N_W-1:0] div_dvd;
    logic [DIV_D_W-1:0] div_dvs;
    logic               div_start;
    logic               div_done;
    logic [DIV_N_W-1:0] div_q;
    logic [SCAN_W-1:0]  cnt_lt;
    logic [SCAN_W-1:0]  cnt_le;
    logic [SCAN_W-1:0]  k_hi;
    logic [SCAN_W-1:0]  k_lo;
    logic               hit_lo;
    logic               hit_hi;
    logic               flag;
    logic               kept;
    logic               lwr;
    logic               fetch_hit;
    logic [FCNT_W-1:0]  rp_inc;
    logic [D_W:0]       med_sum;
    logic [AMUL_W:0]    am_full;

    // Load bookkeeping: the first load after an analysis starts over.
    assign eff_total = ready_reg ? '0 : total_reg;
    assign store_ok  = eff_total < FCNT_W'(MAX_FRAMES);

    // Effective window length, clamped to the supported range.
    always_comb
    begin
        if (window_reg == '0)
            len_eff = SCAN_W'(1);
        else if (32'(window_reg) > MAX_WINDOW)
            len_eff = SCAN_W'(MAX_WINDOW);
        else
            len_eff = SCAN_W'(window_reg);
    end

    // Ring pointer wrap.
    assign hpos_inc = ({1'b0, hpos_reg} + 1'b1 == len_eff) ? '0 : hpos_reg + 1'b1;
    assign wpos_inc = ({1'b0, wpos_reg} + 1'b1 == len_eff) ? '0 : wpos_reg + 1'b1;

    // Current channel operands.
    assign cur_det    = row_reg[c_reg*DET_W +: DET_W];
    assign cur_peak   = peak_reg[c_reg];
    assign cur_weight = weight_reg[c_reg];

    // Sum of the weights.
    always_comb
    begin
        wsum = '0;
        for (int k = 0; k < CHANNELS; k++)
            wsum = wsum + WSUM_W'(weight_reg[k]);
    end

    // Operand selection of the shared divider.
    always_comb
    begin
        div_start = cmd.div_chan | cmd.div_mean | cmd.div_wmean;
        div_dvs   = DIV_D_W'(len_eff);
        div_dvd   = wtot_reg;
        if (cmd.div_chan)
        begin
            div_dvd = DIV_N_W'({cur_det, {DET_W{1'b0}}});
            div_dvs = DIV_D_W'(cur_peak);
        end
        else if (cmd.div_mean)
        begin
            div_dvd = hsum_reg;
        end
    end

    opp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // Rank of the current candidate within the threshold window.
    always_comb
    begin
        cnt_lt = '0;
        cnt_le = '0;
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            if (SCAN_W'(j) < len_eff)
            begin
                if (win_reg[j] < cand_reg)
                    cnt_lt = cnt_lt + 1'b1;
                if (win_reg[j] <= cand_reg)
                    cnt_le = cnt_le + 1'b1;
            end
        end
        k_hi   = len_eff >> 1;
        k_lo   = len_eff[0] ? k_hi : k_hi - 1'b1;
        hit_lo = (cnt_lt <= k_lo) && (k_lo < cnt_le);
        hit_hi = (cnt_lt <= k_hi) && (k_hi < cnt_le);
    end

    // Threshold terms.
    assign med_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign am_full = {1'b0, phi_reg, {HALF_W{1'b0}}} + (AMUL_W+1)'(plo_reg);

    // Flag of the current frame and the keep rule for the previous one.
    assign flag = cmd.finish | (~sts.first_frame & ({5'b0, m_reg} > thr_reg));
    assign kept = f1_reg & ~f2_reg & flag;
    assign lwr  = (cmd.keep | cmd.finish) & kept;

    // Fetch decision.
    assign fetch_hit = ready_reg && (rp_reg < cnt_reg);
    assign rp_inc    = rp_reg + 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNELS; k++)
                weight_reg[k] <= (k < 2) ? RST_WEIGHT_ON : RST_WEIGHT_OFF;
            alpha_reg   <= RST_ALPHA;
            silence_reg <= RST_SILENCE;
            window_reg  <= RST_WINDOW;
            period_reg  <= RST_PERIOD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WEIGHT_0: weight_reg[0] <= cfg_data;
                CFG_WEIGHT_1: weight_reg[1] <= cfg_data;
                CFG_WEIGHT_2: weight_reg[2] <= cfg_data;
                CFG_WEIGHT_3: weight_reg[3] <= cfg_data;
                CFG_ALPHA:    alpha_reg     <= cfg_data;
                CFG_SILENCE:  silence_reg   <= cfg_data;
                CFG_WINDOW:   window_reg    <= cfg_data[WLEN_W-1:0];
                CFG_PERIOD:   period_reg    <= cfg_data;
                default:      period_reg    <= period_reg;
            endcase
        end
    end

    // Control state: frame count, peaks, list bookkeeping, counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            for (int k = 0; k < CHANNELS; k++)
                peak_reg[k] <= '0;
            ready_reg     <= 1'b0;
            rp_reg        <= '0;
            cnt_reg       <= '0;
            i_reg         <= '0;
            c_reg         <= '0;
            hpos_reg      <= '0;
            wpos_reg      <= '0;
            scan_reg      <= '0;
            cand_vld_reg  <= 1'b0;
            f1_reg        <= 1'b0;
            f2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (ready_reg)
                begin
                    ready_reg <= 1'b0;
                    rp_reg    <= '0;
                    cnt_reg   <= '0;
                end
                for (int k = 0; k < CHANNELS; k++)
                begin
                    if (store_ok && (det[k] > (ready_reg ? '0 : peak_reg[k])))
                        peak_reg[k] <= det[k];
                    else if (ready_reg)
                        peak_reg[k] <= '0;
                end
                total_reg <= store_ok ? eff_total + 1'b1 : eff_total;
            end
            if (cmd.a_init)
            begin
                i_reg    <= '0;
                hpos_reg <= '0;
                wpos_reg <= '0;
                f1_reg   <= 1'b0;
                f2_reg   <= 1'b0;
                cnt_reg  <= '0;
            end
            if (cmd.latch_row)
                c_reg <= '0;
            if (cmd.acc)
                c_reg <= c_reg + 1'b1;
            if (cmd.hist)
                hpos_reg <= hpos_inc;
            if (cmd.win_wr)
            begin
                wpos_reg     <= wpos_inc;
                scan_reg     <= '0;
                cand_vld_reg <= 1'b0;
            end
            if (cmd.scan)
            begin
                cand_vld_reg <= scan_reg < len_eff;
                if (scan_reg < len_eff)
                    scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.keep)
            begin
                f2_reg <= f1_reg;
                f1_reg <= flag;
                i_reg  <= i_reg + 1'b1;
            end
            if (lwr)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.finish)
            begin
                ready_reg <= 1'b1;
                rp_reg    <= '0;
            end
            if (cmd.f_out && fetch_hit)
                rp_reg <= rp_inc;
            if (cmd.f_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Frame store.
    always_ff @(posedge clk)
    begin
        if (cmd.load && store_ok)
            fmem[eff_total[FRAME_AW-1:0]] <= det;
        if (cmd.rd_frame)
            fmem_q <= fmem[i_reg[FRAME_AW-1:0]];
    end

    // Onset list.
    always_ff @(posedge clk)
    begin
        if (lwr)
            lmem[cnt_reg[FRAME_AW-1:0]] <= FRAME_AW'(i_reg - 1'b1);
        if (cmd.f_rd)
            lmem_q <= lmem[rp_reg[FRAME_AW-1:0]];
    end

    // Analysis datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd.a_init)
        begin
            for (int k = 0; k < MAX_WINDOW; k++)
            begin
                hist_reg[k] <= '0;
                win_reg[k]  <= '0;
            end
            hsum_reg  <= '0;
            floor_reg <= silence_reg * wsum;
        end
        if (cmd.latch_row)
        begin
            row_reg <= fmem_q;
            d_reg   <= '0;
        end
        if (cmd.mac)
            prod_reg <= (sts.peak_zero ? '0 : div_q[NRM_W-1:0]) * cur_weight;
        if (cmd.acc)
            d_reg <= d_reg + D_W'(prod_reg);
        if (cmd.hist)
        begin
            hist_reg[hpos_reg] <= d_reg;
            hsum_reg <= hsum_reg - HSUM_W'(hist_reg[hpos_reg]) + HSUM_W'(d_reg);
        end
        if (cmd.silence)
            m_reg <= (div_q < DIV_N_W'(floor_reg)) ? '0 : div_q[D_W-1:0];
        if (cmd.win_wr)
        begin
            win_reg[wpos_reg] <= m_reg;
            wtot_reg          <= '0;
        end
        if (cmd.scan)
        begin
            if (scan_reg < len_eff)
                cand_reg <= win_reg[scan_reg[WIN_AW-1:0]];
            if (cand_vld_reg)
            begin
                wtot_reg <= wtot_reg + HSUM_W'(cand_reg);
                if (hit_lo)
                    lo_reg <= cand_reg;
                if (hit_hi)
                    hi_reg <= cand_reg;
            end
        end
        if (cmd.am_lo)
            plo_reg <= alpha_reg * div_q[HALF_W-1:0];
        if (cmd.am_hi)
            phi_reg <= alpha_reg * div_q[D_W-1:HALF_W];
        if (cmd.thr)
            thr_reg <= THR_W'(med_sum[D_W:1]) + THR_W'(am_full[AMUL_W:ALPHA_SH]);
    end

    // Fetch path and output register.
    always_ff @(posedge clk)
    begin
        if (cmd.f_mul)
        begin
            ofr_reg   <= lmem_q;
            otime_reg <= TIME_W'(lmem_q) * TIME_W'(period_reg);
        end
        if (cmd.f_out)
        begin
            found_reg       <= fetch_hit;
            onset_frame_reg <= fetch_hit ? FRAMENO_W'(ofr_reg) : '0;
            onset_time_reg  <= fetch_hit ? otime_reg : '0;
            final_reg       <= fetch_hit && (rp_inc == cnt_reg);
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.div_done    = div_done;
        sts.frame_more  = i_reg < total_reg;
        sts.chan_last   = c_reg == CH_W'(CHANNELS - 1);
        sts.peak_zero   = cur_peak == '0;
        sts.first_frame = i_reg == '0;
        sts.scan_done   = (scan_reg == len_eff) && !cand_vld_reg;
        sts.slot_free   = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign onset_frame = onset_frame_reg;
    assign onset_time  = onset_time_reg;
    assign found       = found_reg;
    assign final_onset = final_reg;

endmodule

@@ tb/sv/onset_peak_picker_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// onset_peak_picker_tb: self-checking testbench of the onset peak picker
// Loads frame sequences, runs the analysis and fetches the onset list. A
// predictor in the testbench computes the expected fetch results, and a
// checker compares each result transaction with the oldest expectation.
// ============================================================================
module onset_peak_picker_tb;
    import opp_pkg::*;

    localparam int MODE_LOAD  = 0;
    localparam int MODE_FETCH = 1;

    typedef struct packed {
        logic [FRAMENO_W-1:0] frame_no;
        logic [TIME_W-1:0]    time_us;
        logic                 hit;
        logic                 last_one;
    } onset_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic mode = 1'b0;
    logic [DET_W-1:0] det_0 = '0, det_1 = '0, det_2 = '0, det_3 = '0;
    logic last_frame = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [FRAMENO_W-1:0] onset_frame;
    logic [TIME_W-1:0] onset_time;
    logic found;
    logic final_onset;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_AW-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    onset_peak_picker u_top (.*);

    always #6 clk = ~clk;

    // Predictor state: registers, stored frames, peaks and the onset list.
    logic [CFG_W-1:0] w_reg [CHANNELS];
    logic [CFG_W-1:0] alpha_reg, silence_reg, period_reg;
    logic [WLEN_W-1:0] wlen_reg;
    logic [DET_W-1:0] frames [MAX_FRAMES][CHANNELS];
    logic [DET_W-1:0] peak [CHANNELS];
    int unsigned n_frames, rd_pos;
    bit list_ok;
    bit marks [MAX_FRAMES];

    onset_rec_t expected_onsets [$];
    int errors = 0;
    int gap_pct = 0;
    int stall_pct = 0;

    // Runs the onset analysis over every stored frame.
    task automatic analyse_frames();
        int unsigned len, hpos, wpos, k, j;
        logic [63:0] hist [MAX_WINDOW];
        logic [63:0] win [MAX_WINDOW];
        logic [63:0] srt [MAX_WINDOW];
        logic [63:0] wsum, floor_lvl, d, s, m, wt, med, thr, v, nv;
        bit flag, prev, cur, nxt;
        len = wlen_reg;
        if (len == 0) len = 1;
        if (len > MAX_WINDOW) len = MAX_WINDOW;
        wsum = 0;
        for (int c = 0; c < CHANNELS; c++) wsum += w_reg[c];
        floor_lvl = silence_reg * wsum;
        for (k = 0; k < MAX_WINDOW; k++) begin hist[k] = 0; win[k] = 0; end
        hpos = 0;
        wpos = 0;
        for (int unsigned i = 0; i < n_frames; i++)
        begin
            d = 0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                v = frames[i][c];
                nv = (peak[c] != 0) ? (v << 16) / peak[c] : 0;
                d += nv * w_reg[c];
            end
            hist[hpos] = d;
            hpos = (hpos + 1) % len;
            s = 0;
            for (k = 0; k < len; k++) s += hist[k];
            m = s / len;
            if (m < floor_lvl) m = 0;
            flag = 0;
            if (i >= 1)
            begin
                win[wpos] = m;
                wpos = (wpos + 1) % len;
                wt = 0;
                for (k = 0; k < len; k++)
                begin
                    wt += win[k];
                    v = win[k];
                    j = k;
                    while (j > 0 && srt[j-1] > v)
                    begin
                        srt[j] = srt[j-1];
                        j--;
                    end
                    srt[j] = v;
                end
                med = (len % 2) ? srt[len/2] : (srt[len/2-1] + srt[len/2]) >> 1;
                thr = med + ((alpha_reg * (wt / len)) >> 12);
                flag = m > thr;
            end
            marks[i] = flag;
        end
        // Keep the first frame of each run of two or more flags, and a lone flag on the last frame.
        prev = 0;
        for (int unsigned i = 0; i < n_frames; i++)
        begin
            cur = marks[i];
            nxt = (i + 1 < n_frames) ? marks[i+1] : 0;
            marks[i] = cur && !prev && (i + 1 == n_frames || nxt);
            prev = cur;
        end
        rd_pos = 0;
        list_ok = 1;
    endtask

    // Updates the predictor with one accepted input transaction.
    task automatic predict_item(bit m, logic [DET_W-1:0] dv [CHANNELS], bit lf);
        onset_rec_t r;
        int unsigned j, k;
        if (m == MODE_LOAD)
        begin
            if (list_ok)
            begin
                n_frames = 0;
                rd_pos = 0;
                list_ok = 0;
                for (int c = 0; c < CHANNELS; c++) peak[c] = 0;
            end
            if (n_frames < MAX_FRAMES)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    frames[n_frames][c] = dv[c];
                    if (dv[c] > peak[c]) peak[c] = dv[c];
                end
                n_frames++;
            end
            if (lf) analyse_frames();
            return;
        end
        r = '0;
        if (list_ok)
        begin
            for (j = rd_pos; j < n_frames; j++)
                if (marks[j]) break;
            if (j < n_frames)
            begin
                r.hit = 1;
                r.frame_no = j[FRAMENO_W-1:0];
                r.time_us = TIME_W'(j * period_reg);
                r.last_one = 1;
                for (k = j + 1; k < n_frames; k++)
                    if (marks[k]) r.last_one = 0;
                rd_pos = j + 1;
            end
            else rd_pos = n_frames;
        end
        expected_onsets = {expected_onsets, r};
    endtask

    // Sends one input transaction, with a random idle gap before it.
    // Valid drops only while idling, so items can follow with no gap.
    task automatic send_item(bit m, logic [DET_W-1:0] dv [CHANNELS], bit lf);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        det_0 <= dv[0];
        det_1 <= dv[1];
        det_2 <= dv[2];
        det_3 <= dv[3];
        last_frame <= lf;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(m, dv, lf);
        @(negedge clk);
    endtask

    task automatic load_frame(logic [DET_W-1:0] a, b, c, d, bit lf);
        logic [DET_W-1:0] dv [CHANNELS];
        dv[0] = a; dv[1] = b; dv[2] = c; dv[3] = d;
        send_item(MODE_LOAD, dv, lf);
    endtask

    task automatic fetch_onset();
        logic [DET_W-1:0] dv [CHANNELS];
        for (int c = 0; c < CHANNELS; c++) dv[c] = DET_W'($urandom);
        send_item(MODE_FETCH, dv, $urandom_range(1));
    endtask

    // Waits for every expected result, then lets the analysis finish.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_onsets.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_WEIGHT_0: w_reg[0] = val;
            CFG_WEIGHT_1: w_reg[1] = val;
            CFG_WEIGHT_2: w_reg[2] = val;
            CFG_WEIGHT_3: w_reg[3] = val;
            CFG_ALPHA:    alpha_reg = val;
            CFG_SILENCE:  silence_reg = val;
            CFG_WINDOW:   wlen_reg = val[WLEN_W-1:0];
            CFG_PERIOD:   period_reg = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Loads a sequence with random spikes, then fetches from its onset list.
    task automatic run_sequence(int unsigned len, int unsigned fetches);
        logic [DET_W-1:0] base, v [CHANNELS];
        for (int unsigned i = 0; i < len; i++)
        begin
            base = ($urandom_range(4) == 0) ? DET_W'($urandom) : DET_W'($urandom_range(3000));
            for (int c = 0; c < CHANNELS; c++)
                v[c] = ($urandom_range(9) == 0) ? DET_W'($urandom) : base ^ DET_W'($urandom_range(255));
            if ($urandom_range(19) == 0) v[$urandom_range(3)] = '0;
            load_frame(v[0], v[1], v[2], v[3], i + 1 == len);
        end
        repeat (fetches) fetch_onset();
    endtask

    task automatic test_directed();
        // Fetch before any list exists.
        fetch_onset();
        // Extremes: zero and full-scale values, silent channel, a clear onset.
        load_frame(16'd0, 16'd0, 16'd0, 16'd0, 0);
        load_frame(16'd0, 16'd0, 16'd0, 16'd0, 0);
        load_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 0);
        load_frame(16'hFFFF, 16'h8000, 16'hFFFF, 16'd0, 0);
        load_frame(16'd1, 16'd2, 16'd3, 16'd0, 0);
        load_frame(16'd0, 16'd0, 16'd0, 16'd0, 0);
        load_frame(16'hFFFF, 16'hFFFF, 16'h0001, 16'd0, 1);
        repeat (4) fetch_onset();
        // A single-frame sequence flagged at its last frame cannot occur.
        load_frame(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1);
        repeat (2) fetch_onset();
        drain();
    endtask

    task automatic test_configs();
        // Extremes of every register.
        write_reg(CFG_WEIGHT_0, 16'hFFFF);
        write_reg(CFG_WEIGHT_1, 16'd0);
        write_reg(CFG_WEIGHT_2, 16'hFFFF);
        write_reg(CFG_WEIGHT_3, 16'hFFFF);
        write_reg(CFG_ALPHA, 16'd0);
        write_reg(CFG_SILENCE, 16'd0);
        write_reg(CFG_WINDOW, 16'd1);
        write_reg(CFG_PERIOD, 16'hFFFF);
        run_sequence(12, 5);
        drain();
        write_reg(CFG_WINDOW, 16'd16);
        write_reg(CFG_ALPHA, 16'hFFFF);
        write_reg(CFG_SILENCE, 16'hFFFF);
        run_sequence(20, 4);
        drain();
        // Out-of-range window values and a zero period.
        write_reg(CFG_WINDOW, 16'd0);
        write_reg(CFG_PERIOD, 16'd0);
        write_reg(CFG_SILENCE, 16'd0);
        run_sequence(10, 4);
        drain();
        write_reg(CFG_WINDOW, 16'd31);
        write_reg(CFG_ALPHA, 16'd100);
        run_sequence(24, 5);
        drain();
    endtask

    task automatic test_random(int unsigned seqs);
        for (int unsigned s = 0; s < seqs; s++)
        begin
            write_reg(CFG_WEIGHT_0, DET_W'($urandom));
            write_reg(CFG_WEIGHT_1, DET_W'($urandom));
            write_reg(CFG_WEIGHT_2, DET_W'($urandom_range(8192)));
            write_reg(CFG_WEIGHT_3, DET_W'($urandom_range(8192)));
            write_reg(CFG_ALPHA, DET_W'($urandom_range(1200)));
            write_reg(CFG_SILENCE, DET_W'($urandom_range(2000)));
            write_reg(CFG_WINDOW, DET_W'($urandom_range(16, 1)));
            write_reg(CFG_PERIOD, DET_W'($urandom));
            run_sequence($urandom_range(30, 4), $urandom_range(6, 2));
            drain();
        end
    endtask

    // Compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        onset_rec_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_onsets.size() == 0)
            begin
                $display("%t unexpected result frame %0d", $time, onset_frame);
                errors++;
            end
            else
            begin
                e = expected_onsets.pop_front();
                if (e.frame_no !== onset_frame || e.time_us !== onset_time ||
                    e.hit !== found || e.last_one !== final_onset)
                begin
                    $display("%t mismatch expected %0d %0d %0d %0d actual %0d %0d %0d %0d",
                             $time, e.frame_no, e.time_us, e.hit, e.last_one,
                             onset_frame, onset_time, found, final_onset);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls at random.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        w_reg[0] = RST_WEIGHT_ON;
        w_reg[1] = RST_WEIGHT_ON;
        w_reg[2] = RST_WEIGHT_OFF;
        w_reg[3] = RST_WEIGHT_OFF;
        alpha_reg = RST_ALPHA;
        silence_reg = RST_SILENCE;
        wlen_reg = RST_WINDOW;
        period_reg = RST_PERIOD;
        n_frames = 0;
        rd_pos = 0;
        list_ok = 0;
        for (int c = 0; c < CHANNELS; c++) peak[c] = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_configs();
        test_random(6);
        gap_pct = 55;
        test_random(5);
        gap_pct = 0;
        stall_pct = 55;
        test_random(5);
        gap_pct = 19;
        stall_pct = 19;
        test_random(5);
        drain();
        repeat (50) @(negedge clk);
        if (errors == 0 && expected_onsets.size() == 0)
            $display("PASS onset_peak_picker");
        else
            $display("FAIL onset_peak_picker");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL onset_peak_picker");
        $finish;
    end
endmodule

@@ files.f @@
rtl/opp_pkg.sv
rtl/opp_div.sv
rtl/opp_ctrl.sv
rtl/opp_dpath.sv
rtl/onset_peak_picker.sv
tb/sv/onset_peak_picker_tb.sv
